// ===== hdl/msfbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame budget evictor package
// Shared payload types, control and status bundles, and default, reset and limit constants.
// ----------------------------------------------------------------------------
package msfbe_pkg;

    localparam int STREAMS_DEF = 32;
    localparam int FRAMES_PER_STREAM_DEF = 8;
    localparam logic [23:0] BUDGET_RESET = 24'd2097152;
    localparam logic [8:0] EVICT_MAX = 9'd511;

    typedef struct packed {
        logic [4:0]  stream_id;
        logic [23:0] frame_bytes;
        logic [47:0] arrival_time;
    } put_t;

    typedef struct packed {
        logic        status;
        logic [31:0] frame_number;
        logic [8:0]  evicted_count;
        logic [23:0] free_bytes;
    } res_t;

    typedef struct packed {
        logic load_in;
        logic cap_s;
        logic drop_rd;
        logic drop;
        logic scan_start;
        logic scan_issue;
        logic admit;
        logic clr_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic sid_ok;
        logic full;
        logic fits;
        logic idx_last;
        logic found;
    } sts_t;

endpackage

// ===== hdl/multi_stream_frame_budget_evictor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-stream frame budget evictor
// Per-stream frame rings under one shared byte budget with oldest-first
// eviction across all streams.
// ----------------------------------------------------------------------------
// Usage:
//   A put transfer (put_valid high, put_stall low) carries stream, size and
//   arrival time. One result transfer follows on res_valid/res_stall with
//   the status, frame number, eviction count and remaining free bytes.
//   The budget is written on the cfg channel; cfg_ready is always high.
// Processing:
//   One put is handled at a time. A put that needs no eviction by age goes
//   through read, full check, budget check, admit read, admit and result;
//   a full ring adds a drop read and a drop. Each eviction by age scans
//   every stream head through the stream table and slot memory.
// Reset:
//   After reset the stream table is cleared one entry per cycle, and
//   put_stall stays high until every entry is cleared.
// Stalls:
//   A finished result waits in the output register while res_stall is high;
//   the next put is already taken but its result holds until that transfer.
// ----------------------------------------------------------------------------
module multi_stream_frame_budget_evictor #(
    parameter int STREAMS = msfbe_pkg::STREAMS_DEF,
    parameter int FRAMES_PER_STREAM = msfbe_pkg::FRAMES_PER_STREAM_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            put_valid,
    output logic            put_stall,
    input  msfbe_pkg::put_t put_data,
    output logic            res_valid,
    input  logic            res_stall,
    output msfbe_pkg::res_t res_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [23:0]     cfg_data
);
    import msfbe_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    msfbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .put_valid (put_valid),
        .put_stall (put_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    msfbe_dp #(.STREAMS(STREAMS), .FRAMES_PER_STREAM(FRAMES_PER_STREAM)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .put_data (put_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .res_data (res_data)
    );

    // A put transfer always starts processing, so the input closes next cycle.
    a_busy_after_put: assert property (@(posedge clk) disable iff (!rst_n)
        put_valid && !put_stall |=> put_stall)
        else $error("input open right after a put transfer");

    a_one_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_step, cmd.drop, cmd.admit}))
        else $error("more than one stream table write source");

    a_one_slot_read: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.scan_issue, cmd.drop_rd}))
        else $error("slot read port claimed twice");

    a_reject_number: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status |-> res_data.frame_number == 32'd0)
        else $error("rejected put carries a frame number");

endmodule

// ===== hdl/msfbe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module msfbe_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/msfbe_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame budget evictor datapath
// Stream table, frame slot memory, byte accounting and the oldest-head scan.
// ----------------------------------------------------------------------------
module msfbe_dp #(
    parameter int STREAMS = msfbe_pkg::STREAMS_DEF,
    parameter int FRAMES_PER_STREAM = msfbe_pkg::FRAMES_PER_STREAM_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  msfbe_pkg::put_t   put_data,
    input  logic              cfg_we,
    input  logic [23:0]       cfg_data,
    input  msfbe_pkg::cmd_t   cmd,
    output msfbe_pkg::sts_t   sts,
    output msfbe_pkg::res_t   res_data
);
    import msfbe_pkg::*;

    localparam int SW   = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int HW   = $clog2(FRAMES_PER_STREAM);
    localparam int CNTW = $clog2(FRAMES_PER_STREAM + 1);
    localparam int NUMW = 32;
    localparam int STW  = NUMW + CNTW + HW;
    localparam int SLW  = SW + HW;
    localparam int AW   = HW + 1;

    logic [23:0]     budget_reg, budget_next;
    logic [24:0]     biu_reg, biu_next;
    logic [SW-1:0]   idx_reg, idx_next;
    logic            v1_reg, v2_reg, found_reg, found_next;

    logic [SW-1:0]   s_reg;
    logic [23:0]     size_reg;
    logic [47:0]     when_reg;
    logic            status_reg;
    logic [31:0]     number_reg;
    logic [8:0]      evict_reg;
    logic [SW-1:0]   p_reg;
    logic [CNTW-1:0] p_held_reg;
    logic [HW-1:0]   p_head_reg;
    logic [NUMW-1:0] p_num_reg;
    logic [SW-1:0]   idx1_reg, idx2_reg;
    logic [CNTW-1:0] held2_reg;
    logic [HW-1:0]   head2_reg;
    logic [NUMW-1:0] num2_reg;
    logic [47:0]     best_reg;
    res_t            res_reg;

    logic [STW-1:0]  st_rd, st_wdata;
    logic [SW-1:0]   st_raddr, st_waddr;
    logic            st_we;
    logic [NUMW-1:0] st_num;
    logic [CNTW-1:0] st_held;
    logic [HW-1:0]   st_head;
    logic [71:0]     sl_rd;
    logic [SLW-1:0]  sl_raddr;
    logic [HW-1:0]   head_inc, tail;
    logic [AW-1:0]   tail_sum;
    logic            better;
    logic [23:0]     free_bytes;

    assign st_num  = st_rd[STW-1 -: NUMW];
    assign st_held = st_rd[CNTW+HW-1 : HW];
    assign st_head = st_rd[HW-1:0];

    assign head_inc = (p_head_reg == HW'(FRAMES_PER_STREAM - 1)) ? '0 : p_head_reg + HW'(1);
    assign tail_sum = AW'(st_head) + AW'(st_held);
    assign tail = (tail_sum >= AW'(FRAMES_PER_STREAM)) ?
                  HW'(tail_sum - AW'(FRAMES_PER_STREAM)) : HW'(tail_sum);

    assign st_raddr = cmd.scan_issue ? idx_reg : s_reg;
    assign sl_raddr = cmd.drop_rd ? {p_reg, p_head_reg} : {idx1_reg, st_head};

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = idx_reg;
        st_wdata = '0;
        if (cmd.clr_step)
        begin
            st_we = 1'b1;
        end
        else if (cmd.drop)
        begin
            st_we    = 1'b1;
            st_waddr = p_reg;
            st_wdata = {p_num_reg, p_held_reg - CNTW'(1), head_inc};
        end
        else if (cmd.admit)
        begin
            st_we    = 1'b1;
            st_waddr = s_reg;
            st_wdata = {st_num + 32'd1, st_held + CNTW'(1), st_head};
        end
    end

    msfbe_ram #(.WIDTH(STW), .DEPTH(STREAMS), .ADDR_W(SW)) u_stab (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rd)
    );

    msfbe_ram #(.WIDTH(72), .DEPTH(STREAMS * (2 ** HW)), .ADDR_W(SLW)) u_slot (
        .clk   (clk),
        .we    (cmd.admit),
        .waddr ({s_reg, tail}),
        .wdata ({size_reg, when_reg}),
        .raddr (sl_raddr),
        .rdata (sl_rd)
    );

    // The head time of a stream under comparison arrives through the stream table read and then the slot read.
    assign better = v2_reg && (held2_reg != '0) && (!found_reg || (sl_rd[47:0] < best_reg));

    assign free_bytes = (25'(budget_reg) > biu_reg) ? 24'(25'(budget_reg) - biu_reg) : '0;

    always_comb
    begin
        budget_next = cfg_we ? cfg_data : budget_reg;
        biu_next    = biu_reg;
        if (cmd.drop)
        begin
            biu_next = biu_reg - 25'(sl_rd[71:48]);
        end
        else if (cmd.admit)
        begin
            biu_next = biu_reg + 25'(size_reg);
        end
        idx_next = idx_reg;
        if (cmd.scan_start)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_issue || cmd.clr_step)
        begin
            idx_next = idx_reg + SW'(1);
        end
        found_next = found_reg;
        if (cmd.scan_start)
        begin
            found_next = 1'b0;
        end
        else if (better)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
            biu_reg    <= '0;
            idx_reg    <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            budget_reg <= budget_next;
            biu_reg    <= biu_next;
            idx_reg    <= idx_next;
            v1_reg     <= cmd.scan_issue;
            v2_reg     <= v1_reg;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg  <= idx_reg;
        idx2_reg  <= idx1_reg;
        held2_reg <= st_held;
        head2_reg <= st_head;
        num2_reg  <= st_num;
        if (cmd.load_in)
        begin
            s_reg      <= SW'(put_data.stream_id);
            size_reg   <= put_data.frame_bytes;
            when_reg   <= put_data.arrival_time;
            status_reg <= 1'b1;
            number_reg <= '0;
            evict_reg  <= '0;
        end
        if (cmd.drop)
        begin
            evict_reg <= (evict_reg == EVICT_MAX) ? evict_reg : evict_reg + 9'd1;
        end
        if (cmd.admit)
        begin
            status_reg <= 1'b0;
            number_reg <= st_num;
        end
        if (cmd.cap_s)
        begin
            p_reg      <= s_reg;
            p_held_reg <= st_held;
            p_head_reg <= st_head;
            p_num_reg  <= st_num;
        end
        else if (better)
        begin
            p_reg      <= idx2_reg;
            p_held_reg <= held2_reg;
            p_head_reg <= head2_reg;
            p_num_reg  <= num2_reg;
            best_reg   <= sl_rd[47:0];
        end
        if (cmd.out_load)
        begin
            res_reg <= '{status: status_reg, frame_number: number_reg,
                         evicted_count: evict_reg, free_bytes: free_bytes};
        end
    end

    assign sts.sid_ok   = 9'(put_data.stream_id) < 9'(STREAMS);
    assign sts.full     = st_held == CNTW'(FRAMES_PER_STREAM);
    assign sts.fits     = (26'(biu_reg) + 26'(size_reg)) <= 26'(budget_reg);
    assign sts.idx_last = idx_reg == SW'(STREAMS - 1);
    assign sts.found    = found_reg;
    assign res_data     = res_reg;

endmodule

// ===== hdl/msfbe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame budget evictor controller
// Sequences table clearing, ring-full drop, eviction scans, admit and result.
// ----------------------------------------------------------------------------
module msfbe_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            put_valid,
    output logic            put_stall,
    output logic            res_valid,
    input  logic            res_stall,
    input  msfbe_pkg::sts_t sts,
    output msfbe_pkg::cmd_t cmd
);
    import msfbe_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RDS, S_FULL, S_DRP_RD, S_DRP, S_CHECK,
        S_SCAN, S_SC1, S_SC2, S_SEL, S_ADM_RD, S_ADM, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (put_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = sts.sid_ok ? S_RDS : S_FIN;
                end
            end
            S_RDS:    state_next = S_FULL;
            S_FULL:
            begin
                cmd.cap_s  = 1'b1;
                state_next = sts.full ? S_DRP_RD : S_CHECK;
            end
            S_DRP_RD:
            begin
                cmd.drop_rd = 1'b1;
                state_next  = S_DRP;
            end
            S_DRP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.fits)
                begin
                    state_next = S_ADM_RD;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_SC1;
                end
            end
            S_SC1:    state_next = S_SC2;
            S_SC2:    state_next = S_SEL;
            S_SEL:    state_next = sts.found ? S_DRP_RD : S_FIN;
            S_ADM_RD: state_next = S_ADM;
            S_ADM:
            begin
                cmd.admit  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase

        res_valid_next = res_valid_reg;
        if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign put_stall = state_reg != S_IDLE;
    assign res_valid = res_valid_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame budget evictor testbench
// Drives puts and budget writes into the evictor, predicts each result with
// a behavioral model of the per-stream rings and the shared budget, and
// compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb;
    import msfbe_pkg::*;

    localparam int NSTR = 32;
    localparam int NFR = 8;
    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        put_valid;
    logic        put_stall;
    put_t        put_data;
    logic        res_valid;
    logic        res_stall;
    res_t        res_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [23:0] cfg_data;

    multi_stream_frame_budget_evictor u_top (
        .clk(clk), .rst_n(rst_n),
        .put_valid(put_valid), .put_stall(put_stall), .put_data(put_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Shadow copy of the block's state.
    logic [23:0] budget;
    logic [31:0] seq_next [NSTR];
    int          held [NSTR];
    int          head [NSTR];
    logic [23:0] rec_bytes [NSTR*NFR];
    logic [47:0] rec_time [NSTR*NFR];
    logic [24:0] used;

    res_t        pending_res [$];
    int          errors;
    int          cycles;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_cycles;
    logic [47:0] clock_us;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void drop_oldest_of(input int s);
        used = used - rec_bytes[s*NFR + head[s]];
        head[s] = (head[s] + 1) % NFR;
        held[s]--;
    endfunction

    function automatic res_t admit_frame(input put_t p);
        res_t r;
        int   n_ev;
        int   pick;
        int   at;
        logic [47:0] best;
        n_ev = 0;
        r = '0;
        r.status = 1'b1;
        if (held[p.stream_id] >= NFR)
        begin
            drop_oldest_of(p.stream_id);
            n_ev++;
        end
        while ({1'b0, used} + p.frame_bytes > budget)
        begin
            pick = -1;
            best = '0;
            for (int i = 0; i < NSTR; i++)
            begin
                if (held[i] != 0 && (pick < 0 || rec_time[i*NFR + head[i]] < best))
                begin
                    pick = i;
                    best = rec_time[i*NFR + head[i]];
                end
            end
            if (pick < 0)
                break;
            drop_oldest_of(pick);
            n_ev++;
        end
        if ({1'b0, used} + p.frame_bytes <= budget)
        begin
            at = p.stream_id*NFR + (head[p.stream_id] + held[p.stream_id]) % NFR;
            rec_bytes[at] = p.frame_bytes;
            rec_time[at] = p.arrival_time;
            held[p.stream_id]++;
            used = used + p.frame_bytes;
            r.frame_number = seq_next[p.stream_id];
            seq_next[p.stream_id] = seq_next[p.stream_id] + 1;
            r.status = 1'b0;
        end
        r.evicted_count = (n_ev > 511) ? EVICT_MAX : 9'(n_ev);
        r.free_bytes = (used < budget) ? 24'(budget - used) : 24'd0;
        return r;
    endfunction

    // Valid stays high after a transfer when the next item follows at once,
    // so it is lowered only by an idle cycle or by a drain.
    task automatic send_put(input logic [4:0] s, input logic [23:0] b,
                            input logic [47:0] t);
        put_t p;
        p.stream_id = s;
        p.frame_bytes = b;
        p.arrival_time = t;
        while ($urandom_range(99) < send_idle_pct)
        begin
            put_valid <= 1'b0;
            @(posedge clk);
        end
        put_valid <= 1'b1;
        put_data <= p;
        @(posedge clk);
        while (put_stall)
            @(posedge clk);
        pending_res.push_back(admit_frame(p));
    endtask

    task automatic drain_results();
        put_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        // Extra settling time after the last expected result has been taken.
        repeat (400) @(posedge clk);
    endtask

    task automatic write_budget(input logic [23:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        budget = v;
    endtask

    function automatic logic [23:0] rand_size();
        case ($urandom_range(9))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom);
            default: return 24'($urandom_range(400000));
        endcase
    endfunction

    task automatic random_puts(input int n);
        logic [47:0] t;
        for (int i = 0; i < n; i++)
        begin
            clock_us = clock_us + $urandom_range(2000);
            t = clock_us;
            // Some arrival times are drawn at random over the whole field and may run backwards.
            if ($urandom_range(19) == 0)
                t = 48'({$urandom, $urandom});
            send_put(5'($urandom), rand_size(), t);
        end
    endtask

    task automatic test_directed();
        send_put(5'd0, 24'd0, 48'd0);
        send_put(5'd31, 24'hFFFFFF, 48'hFFFFFFFFFFFF);
        send_put(5'd31, 24'd1000, 48'd5);
        for (int i = 0; i < 10; i++)
            send_put(5'd3, 24'd100, 48'd100 + i);
        send_put(5'd4, 24'd0, 48'd1);
        send_put(5'd5, 24'd2097152, 48'd50);
        send_put(5'd6, 24'd1, 48'd60);
        send_put(5'd7, 24'd1048576, 48'd60);
        send_put(5'd8, 24'd1048576, 48'd60);
        send_put(5'd9, 24'd2097153, 48'd70);
    endtask

    task automatic test_budget_settings();
        write_budget(24'd1);
        send_put(5'd1, 24'd1, 48'd10);
        send_put(5'd2, 24'd0, 48'd11);
        send_put(5'd2, 24'd2, 48'd12);
        write_budget(24'hFFFFFF);
        random_puts(40);
        write_budget(24'd5000);
        send_put(5'd10, 24'd4000, 48'd9000);
        write_budget(24'd300000);
        random_puts(150);
        write_budget(BUDGET_RESET);
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 83;
        random_puts(200);
        send_idle_pct = 0;
        stall_pct = 83;
        random_puts(200);
        send_idle_pct = 38;
        stall_pct = 38;
        random_puts(200);
        send_idle_pct = 0;
        stall_pct = 0;
        random_puts(200);
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        random_puts(30);
        drain_results();
        random_puts(100);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b1;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        res_t exp_r;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_res.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                exp_r = pending_res.pop_front();
                if (res_data.status !== exp_r.status)
                begin
                    $error("status expected %0d got %0d", exp_r.status, res_data.status);
                    errors++;
                end
                if (res_data.frame_number !== exp_r.frame_number)
                begin
                    $error("frame_number expected %0d got %0d",
                           exp_r.frame_number, res_data.frame_number);
                    errors++;
                end
                if (res_data.evicted_count !== exp_r.evicted_count)
                begin
                    $error("evicted_count expected %0d got %0d",
                           exp_r.evicted_count, res_data.evicted_count);
                    errors++;
                end
                if (res_data.free_bytes !== exp_r.free_bytes)
                begin
                    $error("free_bytes expected %0d got %0d",
                           exp_r.free_bytes, res_data.free_bytes);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("multi_stream_frame_budget_evictor test failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        put_valid = 1'b0;
        put_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        clock_us = 48'd1000;
        budget = BUDGET_RESET;
        used = '0;
        for (int i = 0; i < NSTR; i++)
        begin
            seq_next[i] = '0;
            held[i] = 0;
            head[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_budget_settings();
        test_idle_phases();
        test_backpressure();
        drain_results();
        if (errors == 0 && pending_res.size() == 0)
            $display("multi_stream_frame_budget_evictor test passed");
        else
            $display("multi_stream_frame_budget_evictor test failed");
        $finish;
    end
endmodule
